// ----- hw/rtl/whph_pkg.sv -----
// Shared types and constants for the windowed path-length histogram.
`timescale 1ns / 1ps
package whph_pkg;

	localparam int CFG_W   = 20;
	localparam int IDX_W   = 3;
	localparam int COORD_W = 20;
	localparam int STEP_LW = 21;  // step length width
	localparam int ACC_W   = 42;  // shift-subtract unit numerator / quotient width
	localparam int REM_W   = 26;  // partial remainder width
	localparam int DIV_W   = 20;  // divisor width
	localparam int CNT_W   = 6;   // iteration counter width

	localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ACC_W / 2);

	localparam logic [IDX_W-1:0] REG_BOX_WIDTH      = 3'd0;
	localparam logic [IDX_W-1:0] REG_BOX_HEIGHT     = 3'd1;
	localparam logic [IDX_W-1:0] REG_BIN_WIDTH      = 3'd2;
	localparam logic [IDX_W-1:0] REG_WINDOW_FRAMES  = 3'd3;
	localparam logic [IDX_W-1:0] REG_PARTICLE_COUNT = 3'd4;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
	} in_t;

	typedef struct packed {
		logic [23:0] frame_number;
		logic [5:0]  bin_index;
		logic [16:0] fraction;
		logic        last_bin;
	} out_t;

	typedef struct packed {
		logic             start;
		logic             is_sqrt;
		logic [CNT_W-1:0] steps;
	} unit_cmd_t;

endpackage

// ----- hw/rtl/windowed_path_length_histogram.sv -----
// Top level: sequencer, state memories and output register of the path-length histogram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  in       | in_valid/in_stall  | in_data  : pos_x, pos_y
//  out      | out_valid/out_stall| out_data : frame_number, bin_index, fraction, last_bin
//  cfg      | cfg_we             | cfg_index, cfg_data
//
// First frame: an item only has its position stored. Later frames: each item also takes a
// square root (21 square-root steps in the shared shift-subtract unit) while the window fills,
// and a division as well once it is full (PSW division steps, PSW = 21 + log2(WINDOW_MAX)).
// The last particle of an emitting frame adds one division per bin
// (FW = log2(MAX_PARTICLES + 1) + 16 steps each). in_stall holds new items until one is done.
// Reset is asynchronous; no clearing pass. An out_stall holds the sequencer at the bin.
`timescale 1ns / 1ps
module windowed_path_length_histogram import whph_pkg::*; #(
	parameter int MAX_PARTICLES = 1024,
	parameter int WINDOW_MAX    = 64,
	parameter int NUM_BINS      = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int PW  = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
	localparam int NW  = $clog2(MAX_PARTICLES + 1);
	localparam int SW  = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int WW  = $clog2(WINDOW_MAX + 1);
	localparam int RD  = WINDOW_MAX * MAX_PARTICLES;
	localparam int RW  = RD > 1 ? $clog2(RD) : 1;
	localparam int PSW = STEP_LW + $clog2(WINDOW_MAX);
	localparam int HW  = $clog2(NUM_BINS);
	localparam int FW  = NW + 16;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_RD     = 17'h00002,
		S_WRAP   = 17'h00004,
		S_MULX   = 17'h00008,
		S_MULY   = 17'h00010,
		S_SQS    = 17'h00020,
		S_SQW    = 17'h00040,
		S_UPD    = 17'h00080,
		S_DVS    = 17'h00100,
		S_DVW    = 17'h00200,
		S_BRD    = 17'h00400,
		S_BWR    = 17'h00800,
		S_FIN    = 17'h01000,
		S_ERD    = 17'h02000,
		S_ESTART = 17'h04000,
		S_EWAIT  = 17'h08000,
		S_EPUT   = 17'h10000
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0] box_w_q, box_h_q, bin_w_q;
	logic [6:0]         win_q;
	logic [10:0]        pcnt_q;

	logic [PW-1:0]  p_q;
	logic [SW-1:0]  slot_q;
	logic [WW-1:0]  fill_q;
	logic [23:0]    frame_q, efr_q;
	logic           first_q, full_q, last_q;
	logic [HW-1:0]  high_q, baddr_q;
	logic [NUM_BINS-1:0] bvalid_q;
	logic [COORD_W-1:0]  x_q, y_q;
	logic signed [21:0]  dx_q, dy_q;
	logic [ACC_W-1:0]    sq_q;
	logic [STEP_LW-1:0]  step_q;
	logic [PSW-1:0]      ps_new_q;
	logic                out_valid_q;
	out_t                out_q;

	logic [NW-1:0] n_eff;
	logic [WW-1:0] wf_eff;
	logic          is_last;
	logic          out_free;

	logic [2*COORD_W-1:0] sv_rdata;
	logic [PSW-1:0]       ps_rdata;
	logic [STEP_LW-1:0]   ring_rdata;
	logic [NW-1:0]        bin_rdata;
	logic [RW-1:0]        ring_addr;
	logic [PSW-1:0]       ps_next;
	logic [NW-1:0]        bin_cur;

	logic signed [43:0] mul_p;
	logic signed [21:0] mul_a;

	unit_cmd_t        ucmd;
	logic [ACC_W-1:0] unum, uquo;
	logic [DIV_W-1:0] udiv;
	logic             udone;
	logic [HW-1:0]    bin_sat;

	function automatic logic signed [21:0] wrap_axis(input logic signed [20:0] d,
		input logic [COORD_W-1:0] box);
		logic signed [22:0] d0, d1, d2, b;
		begin
			d0 = 23'(d);
			b  = {3'b000, box};
			d1 = ((d0 <<< 1) > b) ? d0 - b : d0;
			d2 = ((d1 <<< 1) < -b) ? d1 + b : d1;
			wrap_axis = d2[21:0];
		end
	endfunction

	always_comb begin
		if (pcnt_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(pcnt_q) > MAX_PARTICLES) begin
			n_eff = NW'(MAX_PARTICLES);
		end else begin
			n_eff = NW'(pcnt_q);
		end
		if (win_q == '0) begin
			wf_eff = WW'(1);
		end else if (32'(win_q) > WINDOW_MAX) begin
			wf_eff = WW'(WINDOW_MAX);
		end else begin
			wf_eff = WW'(win_q);
		end
	end

	assign is_last   = ((NW + 1)'(p_q) + 1'b1) >= (NW + 1)'(n_eff);
	assign ring_addr = RW'(32'(slot_q) * MAX_PARTICLES + 32'(p_q));
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign bin_cur   = bvalid_q[baddr_q] ? bin_rdata : '0;

	always_comb begin
		if (fill_q == '0) begin
			ps_next = PSW'(step_q);
		end else if (!full_q) begin
			ps_next = ps_rdata + PSW'(step_q);
		end else begin
			ps_next = ps_rdata - PSW'(ring_rdata) + PSW'(step_q);
		end
	end

	assign mul_a = (state_q == S_MULX) ? dx_q : dy_q;
	assign mul_p = mul_a * mul_a;

	always_comb begin
		ucmd.start   = (state_q == S_SQS) || (state_q == S_DVS) || (state_q == S_ESTART);
		ucmd.is_sqrt = (state_q == S_SQS);
		if (state_q == S_SQS) begin
			ucmd.steps = SQRT_STEPS;
			unum       = sq_q;
			udiv       = '0;
		end else if (state_q == S_DVS) begin
			ucmd.steps = CNT_W'(PSW);
			unum       = ACC_W'(ps_new_q) << (ACC_W - PSW);
			udiv       = (bin_w_q == '0) ? DIV_W'(1) : DIV_W'(bin_w_q);
		end else begin
			ucmd.steps = CNT_W'(FW);
			unum       = ACC_W'({bin_cur, 16'h0000}) << (ACC_W - FW);
			udiv       = DIV_W'(n_eff);
		end
	end

	assign bin_sat = (uquo >= ACC_W'(NUM_BINS)) ? HW'(NUM_BINS - 1) : uquo[HW-1:0];

	whph_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ucmd),
		.num     (unum),
		.divisor (udiv),
		.done    (udone),
		.quo     (uquo)
	);

	whph_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_PARTICLES)) u_saved (
		.clk   (clk),
		.we    (state_q == S_RD),
		.waddr (p_q),
		.wdata ({x_q, y_q}),
		.raddr (state_q == S_IDLE ? p_q : p_q),
		.rdata (sv_rdata)
	);

	whph_ram #(.WIDTH(PSW), .DEPTH(MAX_PARTICLES)) u_path (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (p_q),
		.wdata (ps_next),
		.raddr (p_q),
		.rdata (ps_rdata)
	);

	whph_ram #(.WIDTH(STEP_LW), .DEPTH(RD)) u_ring (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (ring_addr),
		.wdata (step_q),
		.raddr (ring_addr),
		.rdata (ring_rdata)
	);

	whph_ram #(.WIDTH(NW), .DEPTH(NUM_BINS)) u_bins (
		.clk   (clk),
		.we    (state_q == S_BWR),
		.waddr (baddr_q),
		.wdata (bin_cur + 1'b1),
		.raddr (baddr_q),
		.rdata (bin_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			box_w_q     <= COORD_W'(25600);
			box_h_q     <= COORD_W'(25600);
			bin_w_q     <= COORD_W'(256);
			win_q       <= 7'd10;
			pcnt_q      <= 11'd1024;
			p_q         <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			frame_q     <= '0;
			first_q     <= 1'b1;
			high_q      <= '0;
			bvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EPUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BOX_WIDTH:  box_w_q <= cfg_data;
					REG_BOX_HEIGHT: box_h_q <= cfg_data;
					REG_BIN_WIDTH:  bin_w_q <= cfg_data;
					REG_WINDOW_FRAMES, REG_PARTICLE_COUNT: begin
						if (cfg_index == REG_WINDOW_FRAMES) begin
							win_q <= cfg_data[6:0];
						end else begin
							pcnt_q <= cfg_data[10:0];
						end
						p_q      <= '0;
						slot_q   <= '0;
						fill_q   <= '0;
						first_q  <= 1'b1;
						high_q   <= '0;
						bvalid_q <= '0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_RD;
				S_RD:     state_q <= first_q ? S_FIN : S_WRAP;
				S_WRAP:   state_q <= S_MULX;
				S_MULX:   state_q <= S_MULY;
				S_MULY:   state_q <= S_SQS;
				S_SQS:    state_q <= S_SQW;
				S_SQW:    if (udone) state_q <= S_UPD;
				S_UPD:    state_q <= full_q ? S_DVS : S_FIN;
				S_DVS:    state_q <= S_DVW;
				S_DVW:    if (udone) state_q <= S_BRD;
				S_BRD:    state_q <= S_BWR;
				S_BWR: begin
					bvalid_q[baddr_q] <= 1'b1;
					if (baddr_q > high_q) high_q <= baddr_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					if (last_q) begin
						p_q     <= '0;
						frame_q <= frame_q + 1'b1;
						if (first_q) begin
							first_q <= 1'b0;
						end else begin
							if (full_q) begin
								state_q <= S_ERD;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
							slot_q <= ((WW + 1)'(slot_q) + 1'b1 >= (WW + 1)'(wf_eff)) ?
								'0 : slot_q + 1'b1;
						end
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				S_ERD:    state_q <= S_ESTART;
				S_ESTART: state_q <= S_EWAIT;
				S_EWAIT:  if (udone) state_q <= S_EPUT;
				S_EPUT: begin
					if (out_free) begin
						if (baddr_q == high_q) begin
							bvalid_q <= '0;
							high_q   <= '0;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q    <= in_data.pos_x;
				y_q    <= in_data.pos_y;
				full_q <= (fill_q >= wf_eff);
				last_q <= is_last;
			end
			S_RD: begin
				dx_q <= 22'($signed({1'b0, sv_rdata[2*COORD_W-1:COORD_W]}) -
					$signed({1'b0, x_q}));
				dy_q <= 22'($signed({1'b0, sv_rdata[COORD_W-1:0]}) - $signed({1'b0, y_q}));
			end
			S_WRAP: begin
				dx_q <= wrap_axis(dx_q[20:0], box_w_q);
				dy_q <= wrap_axis(dy_q[20:0], box_h_q);
			end
			S_MULX: sq_q <= ACC_W'($unsigned(mul_p));
			S_MULY: sq_q <= sq_q + ACC_W'($unsigned(mul_p));
			S_SQW:  if (udone) step_q <= uquo[STEP_LW-1:0];
			S_UPD:  ps_new_q <= ps_next;
			S_DVW:  if (udone) baddr_q <= bin_sat;
			S_FIN: begin
				efr_q   <= frame_q;
				baddr_q <= '0;
			end
			S_EPUT: begin
				if (out_free) begin
					out_q.frame_number <= efr_q;
					out_q.bin_index    <= 6'(baddr_q);
					out_q.fraction     <= uquo[16:0];
					out_q.last_bin     <= (baddr_q == high_q);
					if (baddr_q != high_q) baddr_q <= baddr_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ----- hw/rtl/whph_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module whph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/whph_unit.sv -----
// Shared shift-subtract unit: integer square root (2 bits/step) or division (1 bit/step).
`timescale 1ns / 1ps
module whph_unit import whph_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  unit_cmd_t        cmd,
	input  logic [ACC_W-1:0] num,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [ACC_W-1:0] quo
);
	logic             busy_q, sqrt_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] num_q, quo_q;
	logic [REM_W-1:0] rem_q, div_q;
	logic [REM_W-1:0] sh, trial;
	logic             ge;

	always_comb begin
		if (sqrt_q) begin
			sh    = {rem_q[REM_W-3:0], num_q[ACC_W-1 -: 2]};
			trial = {quo_q[REM_W-3:0], 2'b01};
		end else begin
			sh    = {rem_q[REM_W-2:0], num_q[ACC_W-1]};
			trial = div_q;
		end
		ge = (sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.is_sqrt;
			num_q  <= num;
			div_q  <= REM_W'(divisor);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (sh - trial) : sh;
			quo_q <= {quo_q[ACC_W-2:0], ge};
			num_q <= sqrt_q ? {num_q[ACC_W-3:0], 2'b00} : {num_q[ACC_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- hw/rtl/whph_checker.sv -----
// Port-level checks for the path-length histogram, bound to the top level.
`timescale 1ns / 1ps
module whph_checker import whph_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result item changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an item");

	a_fraction_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.fraction <= 17'd65536)
		else $error("fraction above one");
endmodule

bind windowed_path_length_histogram whph_checker u_whph_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
